// ===== design/bgi_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helper functions of the bilinear grid interpolation core
// no dependencies

package bgi_pkg;

   localparam int COORD_W         = 32;
   localparam int VALUE_W         = 32;
   localparam int COUNT_W         = 7;
   localparam int TABLE_ENTRIES   = 4096;
   localparam int TABLE_AW        = $clog2(TABLE_ENTRIES);
   localparam int MAX_AXIS_POINTS = 64;
   localparam int FRAC_W          = 16;
   // width of count minus one, the largest cell multiplier
   localparam int NM1_W           = $clog2(MAX_AXIS_POINTS);
   localparam int PROD_W          = COORD_W + NM1_W;
   localparam int DIV_STEPS       = NM1_W + FRAC_W;
   // corner indices may run one past the table
   localparam int IDX_W           = TABLE_AW + 1;
   localparam int WEIGHT_W        = 2 * FRAC_W + 1;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 32;
   // stages that can each hold one item, input register to output register
   localparam int PIPE_STAGES     = 3 + DIV_STEPS + 6;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_MIN   = 3'd0,
      CSR_X_MAX   = 3'd1,
      CSR_X_COUNT = 3'd2,
      CSR_Y_MIN   = 3'd3,
      CSR_Y_MAX   = 3'd4,
      CSR_Y_COUNT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                      kind;
      logic [TABLE_AW-1:0]       entry_index;
      logic signed [VALUE_W-1:0] entry_value;
   } tag_type;

   typedef struct packed {
      logic [PROD_W-1:0]  prod;
      logic [COORD_W-1:0] span;
      logic               deg;
   } div_axis_type;

   typedef struct packed {
      tag_type      tag;
      div_axis_type x;
      div_axis_type y;
   } div_in_type;

   typedef struct packed {
      tag_type              tag;
      logic [DIV_STEPS-1:0] px;
      logic [DIV_STEPS-1:0] py;
   } div_out_type;

   // partial remainder and a word that holds dividend bits still to come
   // at the top and quotient bits collected at the bottom
   typedef struct packed {
      logic [COORD_W-1:0]   rem;
      logic [DIV_STEPS-1:0] bits;
   } div_state_type;

   function automatic div_state_type div_step(div_state_type s, logic [COORD_W-1:0] span);
      logic [COORD_W:0] t;
      logic             ge;
      div_state_type    r;
      t = {s.rem, s.bits[DIV_STEPS-1]};
      ge = (t >= {1'b0, span});
      r.rem = ge ? COORD_W'(t - {1'b0, span}) : t[COORD_W-1:0];
      r.bits = {s.bits[DIV_STEPS-2:0], ge};
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      if (c < COUNT_W'(2)) r = COUNT_W'(2);
      else if (c > COUNT_W'(MAX_AXIS_POINTS)) r = COUNT_W'(MAX_AXIS_POINTS);
      else r = c;
      return r;
   endfunction

endpackage

// ===== design/bgi_if.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces of the bilinear grid interpolation core
// depends on bgi_pkg

interface bgi_req_if;
   import bgi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [TABLE_AW-1:0]       entry_index;
   logic signed [VALUE_W-1:0] entry_value;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;

   modport source (output valid, kind, entry_index, entry_value, x_coord, y_coord,
                   input ready);
   modport sink (input valid, kind, entry_index, entry_value, x_coord, y_coord,
                 output ready);
endinterface

interface bgi_rsp_if;
   import bgi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] interp_value;

   modport source (output valid, interp_value, input ready);
   modport sink (input valid, interp_value, output ready);
endinterface

// ===== design/bgi_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies

module bgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/bgi_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider for the x and y cell positions, one quotient bit per stage
// depends on bgi_pkg

module bgi_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bgi_pkg::div_in_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output bgi_pkg::div_out_type out_data
);
   import bgi_pkg::*;

   logic          v_ff     [DIV_STEPS];
   tag_type       tag_ff   [DIV_STEPS];
   div_state_type xs_ff    [DIV_STEPS];
   div_state_type ys_ff    [DIV_STEPS];
   logic [COORD_W-1:0] xspan_ff [DIV_STEPS];
   logic [COORD_W-1:0] yspan_ff [DIV_STEPS];
   logic          xdeg_ff  [DIV_STEPS];
   logic          ydeg_ff  [DIV_STEPS];
   logic          en       [DIV_STEPS+1];

   div_state_type x_init, y_init;

   // rem starts at prod / 2^NM1_W, below span since the multiplier is below 2^NM1_W
   assign x_init.rem  = in_data.x.prod[PROD_W-1:NM1_W];
   assign x_init.bits = {in_data.x.prod[NM1_W-1:0], FRAC_W'(0)};
   assign y_init.rem  = in_data.y.prod[PROD_W-1:NM1_W];
   assign y_init.bits = {in_data.y.prod[NM1_W-1:0], FRAC_W'(0)};

   assign en[DIV_STEPS] = out_ready;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
      assign en[k] = !v_ff[k] || en[k+1];

      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= in_valid;
            end
            if (en[k]) begin
               tag_ff[k]   <= in_data.tag;
               xs_ff[k]    <= div_step(x_init, in_data.x.span);
               ys_ff[k]    <= div_step(y_init, in_data.y.span);
               xspan_ff[k] <= in_data.x.span;
               yspan_ff[k] <= in_data.y.span;
               xdeg_ff[k]  <= in_data.x.deg;
               ydeg_ff[k]  <= in_data.y.deg;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
            if (en[k]) begin
               tag_ff[k]   <= tag_ff[k-1];
               xs_ff[k]    <= div_step(xs_ff[k-1], xspan_ff[k-1]);
               ys_ff[k]    <= div_step(ys_ff[k-1], yspan_ff[k-1]);
               xspan_ff[k] <= xspan_ff[k-1];
               yspan_ff[k] <= yspan_ff[k-1];
               xdeg_ff[k]  <= xdeg_ff[k-1];
               ydeg_ff[k]  <= ydeg_ff[k-1];
            end
         end
      end
   end

   assign in_ready      = en[0];
   assign out_valid     = v_ff[DIV_STEPS-1];
   assign out_data.tag  = tag_ff[DIV_STEPS-1];
   // an empty span pins the axis to cell 0, fraction 0
   assign out_data.px   = xdeg_ff[DIV_STEPS-1] ? '0 : xs_ff[DIV_STEPS-1].bits;
   assign out_data.py   = ydeg_ff[DIV_STEPS-1] ? '0 : ys_ff[DIV_STEPS-1].bits;
endmodule

// ===== design/bilinear_grid_interpolation_core.sv =====
`timescale 1ns / 1ps
// top level of the bilinear grid interpolation core
// depends on bgi_pkg, bgi_if, bgi_ram, bgi_div
//
//   channel  dir  beat contents
//   req      in   kind, entry_index, entry_value, x_coord, y_coord
//   rsp      out  interp_value, one beat per query, none per table write
//   csr      in   csr_wr_en, csr_index, csr_wr_data, no read-back
//
// one beat is taken per cycle while rsp is not stalled; a query passes the input, clamp and
// multiply stages, the 22-stage divider, then address, memory, product, sum and out stages.
// table writes land in the four ram copies at the memory stage, in beat order with queries.
// reset clears control and config; the table is not cleared and holds garbage until written.
// a stall on rsp backs up stage by stage, so empty stages still fill while a result waits.

module bilinear_grid_interpolation_core (
   input  logic                                 clock,
   input  logic                                 reset,
   bgi_req_if.sink                              req,
   bgi_rsp_if.source                            rsp,
   input  logic                                 csr_wr_en,
   input  logic [bgi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bgi_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import bgi_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] off;
      logic [COORD_W-1:0] span;
      logic               deg;
   } prep_type;

   function automatic prep_type axis_prep(logic signed [COORD_W-1:0] c,
                                          logic signed [COORD_W-1:0] lo,
                                          logic signed [COORD_W-1:0] hi);
      logic signed [COORD_W-1:0] cc;
      prep_type                  r;
      r.deg = (hi <= lo);
      if (c <= lo) cc = lo;
      else if (c >= hi) cc = COORD_W'(hi - 1);
      else cc = c;
      // unless the span is empty, both differences lie in 0..2^32-1, so the low bits are exact
      r.off  = COORD_W'(cc - lo);
      r.span = COORD_W'(hi - lo);
      return r;
   endfunction

   // config
   logic signed [COORD_W-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [COUNT_W-1:0]        x_count_ff, y_count_ff;
   logic [COUNT_W-1:0]        xn, yn;
   logic [NM1_W-1:0]          x_nm1, y_nm1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff   <= '0;
         x_max_ff   <= COORD_W'(65536);
         x_count_ff <= COUNT_W'(2);
         y_min_ff   <= '0;
         y_max_ff   <= COORD_W'(65536);
         y_count_ff <= COUNT_W'(2);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_X_MIN:   x_min_ff   <= csr_wr_data;
            CSR_X_MAX:   x_max_ff   <= csr_wr_data;
            CSR_X_COUNT: x_count_ff <= csr_wr_data[COUNT_W-1:0];
            CSR_Y_MIN:   y_min_ff   <= csr_wr_data;
            CSR_Y_MAX:   y_max_ff   <= csr_wr_data;
            CSR_Y_COUNT: y_count_ff <= csr_wr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign xn    = sat_count(x_count_ff);
   assign yn    = sat_count(y_count_ff);
   assign x_nm1 = NM1_W'(xn - COUNT_W'(1));
   assign y_nm1 = NM1_W'(yn - COUNT_W'(1));

   // stage enables, back to front
   logic en_p1, en_p2, en_p3, en_addr, en_mem, en_mul, en_s1, en_s2, en_out;
   logic p1_v_ff, p2_v_ff, p3_v_ff, addr_v_ff, mem_v_ff, mul_v_ff, s1_v_ff, s2_v_ff;
   logic out_v_ff;
   logic div_in_ready, div_out_valid;
   div_in_type  div_in;
   div_out_type div_out;

   assign en_out  = !out_v_ff || rsp.ready;
   assign en_s2   = !s2_v_ff || en_out;
   assign en_s1   = !s1_v_ff || en_s2;
   assign en_mul  = !mul_v_ff || en_s1;
   assign en_mem  = !mem_v_ff || en_mul;
   assign en_addr = !addr_v_ff || en_mem;
   assign en_p3   = !p3_v_ff || div_in_ready;
   assign en_p2   = !p2_v_ff || en_p3;
   assign en_p1   = !p1_v_ff || en_p2;
   assign req.ready = en_p1;

   // input register
   tag_type                   p1_tag_ff;
   logic signed [COORD_W-1:0] p1_x_ff, p1_y_ff;
   // clamp and offset
   tag_type                   p2_tag_ff;
   prep_type                  p2_x_ff, p2_y_ff;
   // offset times cell count
   tag_type                   p3_tag_ff;
   div_axis_type              p3_x_ff, p3_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else begin
         if (en_p1) p1_v_ff <= req.valid;
         if (en_p2) p2_v_ff <= p1_v_ff;
         if (en_p3) p3_v_ff <= p2_v_ff;
      end
      if (en_p1) begin
         p1_tag_ff.kind        <= req.kind;
         p1_tag_ff.entry_index <= req.entry_index;
         p1_tag_ff.entry_value <= req.entry_value;
         p1_x_ff               <= req.x_coord;
         p1_y_ff               <= req.y_coord;
      end
      if (en_p2) begin
         p2_tag_ff <= p1_tag_ff;
         p2_x_ff   <= axis_prep(p1_x_ff, x_min_ff, x_max_ff);
         p2_y_ff   <= axis_prep(p1_y_ff, y_min_ff, y_max_ff);
      end
      if (en_p3) begin
         p3_tag_ff    <= p2_tag_ff;
         p3_x_ff.prod <= PROD_W'(p2_x_ff.off) * PROD_W'(x_nm1);
         p3_x_ff.span <= p2_x_ff.span;
         p3_x_ff.deg  <= p2_x_ff.deg;
         p3_y_ff.prod <= PROD_W'(p2_y_ff.off) * PROD_W'(y_nm1);
         p3_y_ff.span <= p2_y_ff.span;
         p3_y_ff.deg  <= p2_y_ff.deg;
      end
   end

   assign div_in.tag = p3_tag_ff;
   assign div_in.x   = p3_x_ff;
   assign div_in.y   = p3_y_ff;

   bgi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p3_v_ff),
      .in_ready  (div_in_ready),
      .in_data   (div_in),
      .out_valid (div_out_valid),
      .out_ready (en_addr),
      .out_data  (div_out)
   );

   // corner addresses and weights; corner order: base, base+yn, base+1, base+yn+1
   logic [NM1_W-1:0]  xi, yi;
   logic [IDX_W-1:0]  base;
   tag_type           addr_tag_ff;
   logic [IDX_W-1:0]  addr_idx_ff [4];
   logic [FRAC_W:0]   fx_ff, fy_ff, gx_ff, gy_ff;

   assign xi   = div_out.px[DIV_STEPS-1:FRAC_W];
   assign yi   = div_out.py[DIV_STEPS-1:FRAC_W];
   assign base = IDX_W'(xi) * IDX_W'(yn) + IDX_W'(yi);

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_v_ff <= 1'b0;
      end else if (en_addr) begin
         addr_v_ff <= div_out_valid;
      end
      if (en_addr) begin
         addr_tag_ff    <= div_out.tag;
         addr_idx_ff[0] <= base;
         addr_idx_ff[1] <= base + IDX_W'(yn);
         addr_idx_ff[2] <= base + IDX_W'(1);
         addr_idx_ff[3] <= base + IDX_W'(yn) + IDX_W'(1);
         fx_ff <= {1'b0, div_out.px[FRAC_W-1:0]};
         fy_ff <= {1'b0, div_out.py[FRAC_W-1:0]};
         gx_ff <= (FRAC_W+1)'(1 << FRAC_W) - {1'b0, div_out.px[FRAC_W-1:0]};
         gy_ff <= (FRAC_W+1)'(1 << FRAC_W) - {1'b0, div_out.py[FRAC_W-1:0]};
      end
   end

   // memory stage: four copies of the table, one read port per corner
   logic                      ram_wr_en, ram_rd_en;
   logic signed [VALUE_W-1:0] rd_data [4];
   logic                      mem_kind_ff;
   logic                      mem_oob_ff [4];
   logic [WEIGHT_W-1:0]       mem_w_ff   [4];

   assign ram_wr_en = en_mem && addr_v_ff && (addr_tag_ff.kind == KIND_WRITE);
   assign ram_rd_en = en_mem && addr_v_ff && (addr_tag_ff.kind == KIND_QUERY);

   for (genvar k = 0; k < 4; k++) begin : g_corner
      bgi_ram #(
         .WIDTH (VALUE_W),
         .DEPTH (TABLE_ENTRIES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr_en),
         .wr_addr (addr_tag_ff.entry_index),
         .wr_data (addr_tag_ff.entry_value),
         .rd_en   (ram_rd_en),
         .rd_addr (addr_idx_ff[k][TABLE_AW-1:0]),
         .rd_data (rd_data[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_v_ff <= 1'b0;
      end else if (en_mem) begin
         mem_v_ff <= addr_v_ff;
      end
      if (en_mem) begin
         mem_kind_ff <= addr_tag_ff.kind;
         for (int k = 0; k < 4; k++) begin
            mem_oob_ff[k] <= addr_idx_ff[k][IDX_W-1];
         end
         mem_w_ff[0] <= WEIGHT_W'(gx_ff * gy_ff);
         mem_w_ff[1] <= WEIGHT_W'(fx_ff * gy_ff);
         mem_w_ff[2] <= WEIGHT_W'(gx_ff * fy_ff);
         mem_w_ff[3] <= WEIGHT_W'(fx_ff * fy_ff);
      end
   end

   // weighted corners, then a two-level sum
   localparam int SUM_W = VALUE_W + WEIGHT_W + 1;
   logic signed [SUM_W-1:0] mul_p_ff [4];
   logic signed [SUM_W-1:0] s1_a_ff, s1_b_ff, s2_sum_ff;
   logic signed [SUM_W-1:0] rnd;
   logic signed [SUM_W-1:0] shr;
   logic signed [VALUE_W-1:0] out_value_ff, sat_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         // table writes end at the memory stage
         if (en_mul) mul_v_ff <= mem_v_ff && (mem_kind_ff == KIND_QUERY);
         if (en_s1)  s1_v_ff  <= mul_v_ff;
         if (en_s2)  s2_v_ff  <= s1_v_ff;
         if (en_out) out_v_ff <= s2_v_ff;
      end
      if (en_mul) begin
         for (int k = 0; k < 4; k++) begin
            mul_p_ff[k] <= mem_oob_ff[k] ? '0 :
               SUM_W'(rd_data[k]) * SUM_W'($signed({1'b0, mem_w_ff[k]}));
         end
      end
      if (en_s1) begin
         s1_a_ff <= mul_p_ff[0] + mul_p_ff[1];
         s1_b_ff <= mul_p_ff[2] + mul_p_ff[3];
      end
      if (en_s2) begin
         s2_sum_ff <= s1_a_ff + s1_b_ff;
      end
      if (en_out) begin
         out_value_ff <= sat_value;
      end
   end

   // round half up, then saturate
   assign rnd = s2_sum_ff + SUM_W'(64'sh8000_0000);
   assign shr = rnd >>> (2 * FRAC_W);

   always_comb begin
      priority if (shr > SUM_W'(64'sh7FFF_FFFF)) begin
         sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (shr < -SUM_W'(64'sh8000_0000)) begin
         sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat_value = shr[VALUE_W-1:0];
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.interp_value = out_value_ff;
endmodule

// ===== design/bgi_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the bilinear grid interpolation core, attached by bind
// depends on bgi_pkg and bilinear_grid_interpolation_core

module bgi_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bgi_pkg::VALUE_W-1:0]  rsp_interp_value
);
   import bgi_pkg::*;

   localparam int PEND_W = $clog2(PIPE_STAGES + 1) + 1;

   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              q_beat, r_beat;

   assign q_beat = req_valid && req_ready && (req_kind == KIND_QUERY);
   assign r_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (q_beat && !r_beat) pending_in = pending_ff + PEND_W'(1);
      if (!q_beat && r_beat) pending_in = pending_ff - PEND_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a result only for a query taken earlier
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("rsp beat with no outstanding query");

   // no more queries in flight than the pipeline holds
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PEND_W'(PIPE_STAGES))
      else $error("more queries in flight than pipeline stages");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_interp_value))
      else $error("stalled rsp beat changed");
endmodule

bind bilinear_grid_interpolation_core bgi_checker u_bgi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_kind         (req.kind),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_interp_value (rsp.interp_value)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for bilinear_grid_interpolation_core: directed and random grid
// loads and queries under several idle and stall patterns, predicted in place
// depends on bgi_pkg, bgi_if and the core

module testbench;
   import bgi_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 5000;
   localparam longint ONE      = 65536;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   bgi_req_if req_ch ();
   bgi_rsp_if rsp_ch ();

   bilinear_grid_interpolation_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic signed [VALUE_W-1:0] grid_copy [TABLE_ENTRIES];
   longint x_lo, x_hi, y_lo, y_hi;
   int x_pts, y_pts;
   logic signed [VALUE_W-1:0] interp_expected [$];

   int send_idle_pct;
   int rsp_stall_pct;
   longint cycle_count;
   longint hold_end;
   int idle_cycles;
   int errors;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_WRITE;
      req_ch.entry_index = '0;
      req_ch.entry_value = '0;
      req_ch.x_coord = '0;
      req_ch.y_coord = '0;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_X_MIN;
      csr_wr_data = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      cycle_count = 0;
      hold_end = 0;
      idle_cycles = 0;
      errors = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count < hold_end) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (interp_expected.size() == 0) begin
            $error("interp_value: unexpected beat, actual %0d", rsp_ch.interp_value);
            errors++;
         end else begin
            if (rsp_ch.interp_value !== interp_expected[0]) begin
               $error("interp_value: expected %0d, actual %0d",
                      interp_expected[0], rsp_ch.interp_value);
               errors++;
            end
            void'(interp_expected.pop_front());
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int clamp_count(int c);
      if (c < 2) return 2;
      if (c > MAX_AXIS_POINTS) return MAX_AXIS_POINTS;
      return c;
   endfunction

   // cell index in the upper bits, fraction in the low 16
   function automatic bit [63:0] cell_position(longint c, longint lo, longint hi, int pts);
      bit [63:0] span;
      bit [63:0] off;
      if (hi <= lo) return 64'd0;
      if (c <= lo) c = lo;
      if (c >= hi) c = hi - 1;
      span = hi - lo;
      off = c - lo;
      return (off * (pts - 1) * 64'd65536) / span;
   endfunction

   function automatic longint corner(longint idx);
      if (idx >= TABLE_ENTRIES) return 0;
      return longint'(grid_copy[idx]);
   endfunction

   function automatic logic signed [VALUE_W-1:0] blend_query(longint xq, longint yq);
      bit [63:0] px, py, u, r;
      longint fx, fy, gx, gy, base, sum, res;
      px = cell_position(xq, x_lo, x_hi, x_pts);
      py = cell_position(yq, y_lo, y_hi, y_pts);
      fx = px[15:0];
      fy = py[15:0];
      gx = ONE - fx;
      gy = ONE - fy;
      base = longint'(px >> 16) * y_pts + longint'(py >> 16);
      sum = corner(base) * (gx * gy) + corner(base + y_pts) * (fx * gy)
          + corner(base + 1) * (gx * fy) + corner(base + y_pts + 1) * (fx * fy);
      u = sum + 64'h8000_0000_0000_0000;
      r = (u + 64'h8000_0000) >> 32;
      res = longint'(r) - 64'sh8000_0000;
      if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
      if (res < -64'sh8000_0000) res = -64'sh8000_0000;
      return res[31:0];
   endfunction

   task automatic send_beat(kind_type kind, int idx, logic [31:0] val,
                            logic [31:0] xq, logic [31:0] yq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.entry_index <= idx[TABLE_AW-1:0];
      req_ch.entry_value <= val;
      req_ch.x_coord <= xq;
      req_ch.y_coord <= yq;
      do @(posedge clock); while (!req_ch.ready);
      if (kind == KIND_WRITE) grid_copy[idx[TABLE_AW-1:0]] = val;
      else interp_expected.insert(interp_expected.size(),
                                  blend_query(longint'(signed'(xq)),
                                              longint'(signed'(yq))));
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return $urandom_range(262144) - 131072;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_coord(longint lo, longint hi);
      longint span, v;
      bit [63:0] r;
      span = hi - lo;
      if (span <= 0 || $urandom_range(9) == 0) return $urandom;
      case ($urandom_range(9))
         0: return lo[31:0];
         1: return hi[31:0];
         2: begin
            v = hi - 1;
            return v[31:0];
         end
         default: begin
            r = {$urandom, $urandom};
            v = lo - span / 8 + longint'(r % (span + span / 4 + 1));
            if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000) v = -64'sh8000_0000;
            return v[31:0];
         end
      endcase
   endfunction

   // drain the pipe, write all registers, then load every grid point in use
   task automatic set_grid(longint xl, longint xh, int xc, longint yl, longint yh, int yc);
      int n;
      req_ch.valid <= 1'b0;
      while (interp_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_X_MIN;   csr_wr_data <= xl[31:0]; @(posedge clock);
      csr_index <= CSR_X_MAX;   csr_wr_data <= xh[31:0]; @(posedge clock);
      csr_index <= CSR_X_COUNT; csr_wr_data <= xc;       @(posedge clock);
      csr_index <= CSR_Y_MIN;   csr_wr_data <= yl[31:0]; @(posedge clock);
      csr_index <= CSR_Y_MAX;   csr_wr_data <= yh[31:0]; @(posedge clock);
      csr_index <= CSR_Y_COUNT; csr_wr_data <= yc;       @(posedge clock);
      csr_wr_en <= 1'b0;
      x_lo = xl; x_hi = xh; x_pts = clamp_count(xc & 8'h7F);
      y_lo = yl; y_hi = yh; y_pts = clamp_count(yc & 8'h7F);
      n = x_pts * y_pts;
      for (int i = 0; i < n; i++)
         send_beat(KIND_WRITE, i, pick_value(), $urandom, $urandom);
   endtask

   task automatic random_traffic(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(4) == 0)
            send_beat(KIND_WRITE, $urandom_range(TABLE_ENTRIES - 1), pick_value(),
                      $urandom, $urandom);
         else
            send_beat(KIND_QUERY, $urandom_range(TABLE_ENTRIES - 1), $urandom,
                      pick_coord(x_lo, x_hi), pick_coord(y_lo, y_hi));
      end
   endtask

   task automatic test_directed_corners();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_grid(0, ONE, 2, 0, ONE, 2);
      // all corners at full scale, then at the negative extreme
      for (int i = 0; i < 4; i++) send_beat(KIND_WRITE, i, 32'h7FFF_FFFF, 0, 0);
      send_beat(KIND_QUERY, 0, 0, 32'h0000_8000, 32'h0000_8000);
      for (int i = 0; i < 4; i++) send_beat(KIND_WRITE, i, 32'h8000_0000, 0, 0);
      send_beat(KIND_QUERY, 0, 0, 32'h0000_4000, 32'h0000_C000);
      send_beat(KIND_WRITE, 0, 32'h0001_0000, 0, 0);
      send_beat(KIND_WRITE, 1, 32'hFFFF_0000, 0, 0);
      send_beat(KIND_WRITE, 2, 32'h7FFF_FFFF, 0, 0);
      send_beat(KIND_WRITE, TABLE_ENTRIES - 1, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // below min, at min, at max, above max, word extremes
      send_beat(KIND_QUERY, 0, 0, 32'h8000_0000, 32'h8000_0000);
      send_beat(KIND_QUERY, 0, 0, 32'h0, 32'h0);
      send_beat(KIND_QUERY, 0, 0, 32'h0001_0000, 32'h0001_0000);
      send_beat(KIND_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_beat(KIND_QUERY, 0, 0, 32'h0000_FFFF, 32'h0);
      send_beat(KIND_QUERY, 0, 0, 32'h0, 32'h0000_FFFF);
      send_beat(KIND_QUERY, 0, 0, 32'h0000_3333, 32'h8000_0000);
   endtask

   task automatic test_full_range_grid();
      set_grid(-64'sh8000_0000, 64'sh7FFF_FFFF, MAX_AXIS_POINTS,
               -64'sh8000_0000, 64'sh7FFF_FFFF, 2);
      send_beat(KIND_QUERY, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(KIND_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_beat(KIND_QUERY, 0, 0, 32'h7FFF_FFFE, 32'h7FFF_FFFE);
      random_traffic(60);
   endtask

   task automatic test_degenerate_axes();
      // empty spans on x and on y, counts off both ends of the legal range
      set_grid(ONE, ONE, 1, 5 * ONE, -3 * ONE, 100);
      random_traffic(30);
      set_grid(-ONE, 4 * ONE, 127, 2 * ONE, ONE, 0);
      random_traffic(30);
   endtask

   task automatic test_random_grids();
      longint lo, span;
      longint ylo, yspan;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 80; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 80; end
            default: begin send_idle_pct = 13; rsp_stall_pct = 13; end
         endcase
         lo = longint'(signed'($urandom)) / ($urandom_range(1) ? 1 : 4096);
         span = $urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(16);
         if (lo + span > 64'sh7FFF_FFFF) lo = 64'sh7FFF_FFFF - span;
         ylo = longint'(signed'($urandom)) / ($urandom_range(1) ? 1 : 4096);
         yspan = $urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(16);
         if (ylo + yspan > 64'sh7FFF_FFFF) ylo = 64'sh7FFF_FFFF - yspan;
         set_grid(lo, lo + span, $urandom_range(6, 2),
                  ylo, ylo + yspan, $urandom_range(6, 2));
         random_traffic(40);
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_grid(-2 * ONE, 3 * ONE, 5, -ONE, ONE, 4);
      hold_end = cycle_count + 300;
      random_traffic(120);
   endtask

   initial begin
      @(negedge reset);
      @(posedge clock);
      test_directed_corners();
      test_full_range_grid();
      test_degenerate_axes();
      test_backpressure();
      test_random_grids();
      req_ch.valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (interp_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bgi_pkg.sv
design/bgi_if.sv
design/bgi_ram.sv
design/bgi_div.sv
design/bilinear_grid_interpolation_core.sv
design/bgi_checker.sv
bench/testbench.sv
